/* rtl/gms_pkg.sv */
// ============================================================================
// gms_pkg - shared types and constants of the glyph match scorer
// Beat layouts, configuration codes, the job word passed from the front end
// to the scoring engine, and the byte popcount helper.
// ============================================================================
package gms_pkg;

    localparam int PATCH_BYTES_DEF = 512;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PIX_W      = 8;
    localparam int POP_W      = 4;
    localparam int CODE_W     = 21;
    localparam int SCORE_W    = 17;
    localparam int NOISE_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [SCORE_W-1:0] FULL_SCORE = 17'h10000;

    // Item kinds.
    localparam logic KIND_REF   = 1'b0;
    localparam logic KIND_GLYPH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT      = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  pix_bits;
        logic [CODE_W-1:0] glyph_code;
        logic              last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [SCORE_W-1:0] glyph_score;
        logic [CODE_W-1:0]  best_code;
        logic [SCORE_W-1:0] best_score;
        logic               search_done;
    } t_out_beat;

    typedef struct packed {
        logic [NOISE_W-1:0] noise_limit_pixels;
        logic [SCORE_W-1:0] accept_threshold;
    } t_cfg;

    // One classified byte on its way to the scoring engine.
    typedef struct packed {
        logic              kind;
        logic              restart;   // reference byte that opens a new patch
        logic              counted;   // byte lies inside the patch window
        logic [POP_W-1:0]  ovl_pop;   // popcount of glyph AND reference
        logic [POP_W-1:0]  pix_pop;   // popcount of the byte itself
        logic              last;
        logic [CODE_W-1:0] code;
    } t_job;

    function automatic logic [POP_W-1:0] pop8(input logic [PIX_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < PIX_W; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

/* rtl/gms_ram.sv */
// ============================================================================
// gms_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module gms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gms_front.sv */
// ============================================================================
// gms_front - input side of the glyph match scorer
// Accepts bytes, writes reference bytes into the patch store, reads the
// reference byte under each glyph byte and hands classified jobs onward.
// ============================================================================
module gms_front #(
    parameter int PATCH_BYTES = gms_pkg::PATCH_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gms_pkg::t_in_beat i_in_beat,
    output logic              o_in_ready,
    output logic              o_job_valid,
    output gms_pkg::t_job     o_job,
    input  logic              i_job_ready
);

    localparam int AW = $clog2(PATCH_BYTES);
    localparam int LW = $clog2(PATCH_BYTES + 1);
    localparam logic [LW-1:0] LIMIT = LW'(PATCH_BYTES);

    logic [LW-1:0]    r_len, n_len;
    logic             r_closed, n_closed;
    logic [LW-1:0]    r_bpos, n_bpos;
    logic             r_s1_valid, n_s1_valid;
    gms_pkg::t_job    r_s1_job, n_s1_job;
    logic [gms_pkg::PIX_W-1:0] r_s1_pix, n_s1_pix;
    logic             r_s1_in_patch, n_s1_in_patch;

    logic             w_accept;
    logic [LW-1:0]    w_len_eff;
    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [gms_pkg::PIX_W-1:0] w_ref_byte;

    assign o_in_ready = !r_s1_valid || i_job_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_len_eff  = r_closed ? '0 : r_len;

    assign w_we    = w_accept && (i_in_beat.kind == gms_pkg::KIND_REF) && (w_len_eff < LIMIT);
    assign w_waddr = w_len_eff[AW-1:0];
    assign w_re    = w_accept && (i_in_beat.kind == gms_pkg::KIND_GLYPH);
    assign w_raddr = r_bpos[AW-1:0];

    gms_ram #(
        .WIDTH (gms_pkg::PIX_W),
        .DEPTH (PATCH_BYTES)
    ) u_patch_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_beat.pix_bits),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ref_byte)
    );

    always_comb begin
        n_len         = r_len;
        n_closed      = r_closed;
        n_bpos        = r_bpos;
        n_s1_valid    = r_s1_valid && !i_job_ready;
        n_s1_job      = r_s1_job;
        n_s1_pix      = r_s1_pix;
        n_s1_in_patch = r_s1_in_patch;
        if (w_accept) begin
            n_s1_valid       = 1'b1;
            n_s1_pix         = i_in_beat.pix_bits;
            n_s1_job.kind    = i_in_beat.kind;
            n_s1_job.ovl_pop = '0;
            n_s1_job.pix_pop = gms_pkg::pop8(i_in_beat.pix_bits);
            n_s1_job.last    = i_in_beat.last_byte;
            n_s1_job.code    = i_in_beat.glyph_code;
            if (i_in_beat.kind == gms_pkg::KIND_REF) begin
                n_s1_job.restart = r_closed;
                n_s1_job.counted = w_len_eff < LIMIT;
                n_s1_in_patch    = 1'b0;
                n_len            = (w_len_eff < LIMIT) ? w_len_eff + 1'b1 : w_len_eff;
                n_closed         = i_in_beat.last_byte;
                if (r_closed) begin
                    n_bpos = '0;
                end
            end else begin
                n_s1_job.restart = 1'b0;
                n_s1_job.counted = r_bpos < LIMIT;
                n_s1_in_patch    = r_bpos < r_len;
                if (i_in_beat.last_byte) begin
                    n_bpos = '0;
                end else if (r_bpos < LIMIT) begin
                    n_bpos = r_bpos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_closed   <= 1'b0;
            r_bpos     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_closed   <= n_closed;
            r_bpos     <= n_bpos;
            r_s1_valid <= n_s1_valid;
        end
        r_s1_job      <= n_s1_job;
        r_s1_pix      <= n_s1_pix;
        r_s1_in_patch <= n_s1_in_patch;
    end

    always_comb begin
        o_job = r_s1_job;
        if (r_s1_job.kind == gms_pkg::KIND_GLYPH && r_s1_in_patch) begin
            o_job.ovl_pop = gms_pkg::pop8(w_ref_byte & r_s1_pix);
        end
    end

    assign o_job_valid = r_s1_valid;

endmodule

/* rtl/gms_queue.sv */
// ============================================================================
// gms_queue - short job queue between front end and scoring engine
// A small register FIFO that lets either side stall on its own.
// ============================================================================
module gms_queue #(
    parameter int DEPTH = gms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  gms_pkg::t_job i_push_job,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output gms_pkg::t_job o_pop_job,
    input  logic          i_pop_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    gms_pkg::t_job r_slot [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_push_ready = r_cnt != FULL_CNT;
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_job    = r_slot[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_SLOT) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_SLOT) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_slot[r_wptr] <= i_push_job;
        end
    end

endmodule

/* rtl/gms_back.sv */
// ============================================================================
// gms_back - scoring engine of the glyph match scorer
// Accumulates pixel counts, squares the extraneous count, divides the
// overlap by the penalized union bit by bit and keeps the best glyph.
// ============================================================================
module gms_back #(
    parameter int PATCH_BYTES = gms_pkg::PATCH_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gms_pkg::t_cfg      i_cfg,
    input  logic               i_job_valid,
    input  gms_pkg::t_job      i_job,
    output logic               o_job_ready,
    output logic               o_out_valid,
    output gms_pkg::t_out_beat o_out_beat,
    input  logic               i_out_ready
);

    localparam int CW = $clog2(8 * PATCH_BYTES + 1);
    localparam int SW = 2 * CW;
    localparam int DW = 2 * CW + 1;
    localparam int QW = gms_pkg::SCORE_W;
    localparam int IW = $clog2(QW);

    typedef enum logic [4:0] {
        S_RUN    = 5'b00001,
        S_SQUARE = 5'b00010,
        S_DENOM  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_ovl, n_ovl;
    logic [CW-1:0]              r_gly, n_gly;
    logic [CW-1:0]              r_ref, n_ref;
    logic [gms_pkg::CODE_W-1:0] r_code, n_code;
    logic [gms_pkg::CODE_W-1:0] r_best_code, n_best_code;
    logic [QW-1:0]              r_best_score, n_best_score;
    logic                       r_stopped, n_stopped;
    logic [CW-1:0]              r_extra, n_extra;
    logic [SW-1:0]              r_sq, n_sq;
    logic [DW-1:0]              r_den, n_den;
    logic [DW:0]                r_rem, n_rem;
    logic [QW-1:0]              r_quo, n_quo;
    logic [IW-1:0]              r_bit, n_bit;
    logic                       r_out_valid, n_out_valid;
    gms_pkg::t_out_beat         r_out, n_out;

    logic [SW-1:0]              w_ext_wide;
    logic [DW-1:0]              w_den;
    logic                       w_full;
    logic                       w_ge;
    logic [DW:0]                w_diff;
    logic [QW-1:0]              w_score;
    logic                       w_better;

    assign o_job_ready = r_state == S_RUN;

    assign w_ext_wide = SW'(r_gly - r_ovl);
    assign w_den      = DW'(r_ref) + DW'(r_extra) + DW'(r_sq);
    assign w_full     = (r_gly == '0) && (32'(r_ref) <= 32'(i_cfg.noise_limit_pixels));
    assign w_ge       = r_rem >= (DW + 1)'(r_den);
    assign w_diff     = w_ge ? r_rem - (DW + 1)'(r_den) : r_rem;
    assign w_score    = (r_quo > gms_pkg::FULL_SCORE) ? gms_pkg::FULL_SCORE : r_quo;
    assign w_better   = w_score >= r_best_score;

    always_comb begin
        n_state      = r_state;
        n_ovl        = r_ovl;
        n_gly        = r_gly;
        n_ref        = r_ref;
        n_code       = r_code;
        n_best_code  = r_best_code;
        n_best_score = r_best_score;
        n_stopped    = r_stopped;
        n_extra      = r_extra;
        n_sq         = r_sq;
        n_den        = r_den;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_bit        = r_bit;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        unique case (r_state)
            S_RUN: begin
                if (i_job_valid) begin
                    if (i_job.kind == gms_pkg::KIND_REF) begin
                        if (i_job.restart) begin
                            n_ovl        = '0;
                            n_gly        = '0;
                            n_best_code  = '0;
                            n_best_score = '0;
                            n_stopped    = 1'b0;
                            n_ref        = i_job.counted ? CW'(i_job.pix_pop) : '0;
                        end else if (i_job.counted) begin
                            n_ref = r_ref + CW'(i_job.pix_pop);
                        end
                    end else if (!r_stopped) begin
                        if (i_job.counted) begin
                            n_ovl = r_ovl + CW'(i_job.ovl_pop);
                            n_gly = r_gly + CW'(i_job.pix_pop);
                        end
                        if (i_job.last) begin
                            n_code  = i_job.code;
                            n_state = S_SQUARE;
                        end
                    end
                end
            end
            S_SQUARE: begin
                n_extra = w_ext_wide[CW-1:0];
                n_sq    = w_ext_wide * w_ext_wide;
                n_state = S_DENOM;
            end
            S_DENOM: begin
                n_den = w_den;
                n_rem = (DW + 1)'(r_ovl);
                n_quo = '0;
                n_bit = IW'(QW - 1);
                if (w_full) begin
                    n_quo   = gms_pkg::FULL_SCORE;
                    n_state = S_FINISH;
                end else if (w_den == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                n_rem = {w_diff[DW-1:0], 1'b0};
                n_quo = {r_quo[QW-2:0], w_ge};
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_best_code  = w_better ? r_code : r_best_code;
                    n_best_score = w_better ? w_score : r_best_score;
                    n_stopped    = r_stopped ||
                                   (w_better && (w_score >= i_cfg.accept_threshold));
                    n_out.glyph_score = w_score;
                    n_out.best_code   = n_best_code;
                    n_out.best_score  = n_best_score;
                    n_out.search_done = n_stopped;
                    n_out_valid       = 1'b1;
                    n_ovl             = '0;
                    n_gly             = '0;
                    n_state           = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_ovl        <= '0;
            r_gly        <= '0;
            r_ref        <= '0;
            r_best_code  <= '0;
            r_best_score <= '0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ovl        <= n_ovl;
            r_gly        <= n_gly;
            r_ref        <= n_ref;
            r_best_code  <= n_best_code;
            r_best_score <= n_best_score;
            r_stopped    <= n_stopped;
            r_out_valid  <= n_out_valid;
        end
        r_code  <= n_code;
        r_extra <= n_extra;
        r_sq    <= n_sq;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_bit   <= n_bit;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

/* rtl/glyph_match_scorer_top.sv */
// ============================================================================
// glyph_match_scorer_top - scores glyph bitmaps against a reference patch
// Top level: configuration registers, front end, job queue, scoring engine.
// ============================================================================
// The block takes one byte beat per cycle while o_in_ready is high.
// Reference bytes (kind 0) fill the patch store and are counted; glyph
// bytes (kind 1) are compared against the stored byte at the same
// position. Only the last byte of a glyph that is scored yields a result
// beat, carrying the glyph's Q1.16 score, the best glyph so far and the
// search-done flag. The last byte of a scored glyph keeps the scoring
// engine busy while it squares the extraneous count, forms the divisor,
// builds the bit-serial quotient, updates the best glyph and loads the
// result; an empty glyph that counts as perfect skips the quotient. The
// engine takes no byte meanwhile, and the front end keeps taking bytes
// only until the job queue of QUEUE_DEPTH entries and its own stage are
// full, that is for QUEUE_DEPTH + 1 bytes. The serial divider thus sets
// the cost of each glyph beyond its bytes, and a stalled result register
// adds its stall on top. The patch store is undefined after reset and
// needs no clearing pass; glyph bytes beyond the loaded patch length
// compare against zero.
// ============================================================================
module glyph_match_scorer_top #(
    parameter int PATCH_BYTES = gms_pkg::PATCH_BYTES_DEF,
    parameter int QUEUE_DEPTH = gms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input beats.
    input  logic                          i_in_valid,
    input  gms_pkg::t_in_beat             i_in_beat,
    output logic                          o_in_ready,
    // Result beats.
    output logic                          o_out_valid,
    output gms_pkg::t_out_beat            o_out_beat,
    input  logic                          i_out_ready,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [gms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gms_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gms_pkg::t_cfg r_cfg;
    logic          w_fq_valid, w_fq_ready;
    gms_pkg::t_job w_fq_job;
    logic          w_qb_valid, w_qb_ready;
    gms_pkg::t_job w_qb_job;

    // Configuration registers. The user must write them only while the block
    // is idle; the block does not enforce this. The engine reads them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_limit_pixels <= '0;
            r_cfg.accept_threshold   <= gms_pkg::FULL_SCORE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gms_pkg::CFG_NOISE_LIMIT: begin
                    r_cfg.noise_limit_pixels <= i_cfg_data[gms_pkg::NOISE_W-1:0];
                end
                gms_pkg::CFG_ACCEPT: begin
                    r_cfg.accept_threshold <= i_cfg_data[gms_pkg::SCORE_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The front end owns the patch store and the byte positions, and turns
    // every accepted beat into one job.
    gms_front #(
        .PATCH_BYTES (PATCH_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_ready  (o_in_ready),
        .o_job_valid (w_fq_valid),
        .o_job       (w_fq_job),
        .i_job_ready (w_fq_ready)
    );

    // Jobs wait here while the engine divides.
    gms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .i_push_job   (w_fq_job),
        .o_push_ready (w_fq_ready),
        .o_pop_valid  (w_qb_valid),
        .o_pop_job    (w_qb_job),
        .i_pop_ready  (w_qb_ready)
    );

    // The engine keeps the counts, the best glyph and the result register.
    gms_back #(
        .PATCH_BYTES (PATCH_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_qb_valid),
        .i_job       (w_qb_job),
        .o_job_ready (w_qb_ready),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_ready (i_out_ready)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking testbench of glyph_match_scorer_top
// Streams reference patches and candidate glyph bitmaps into the scorer. A
// behavioral copy of the scorer predicts each result beat, and every beat
// that comes out is compared field by field. Both sides of the stream stall
// at random, and the configuration moves through several settings.
// ============================================================================
module tb;
    import gms_pkg::*;

    localparam int          PATCH_LEN_MAX = PATCH_BYTES_DEF;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int          PHASE_ITEMS   = 140;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int unsigned CODE_MAX      = 1114111;
    localparam int unsigned NOISE_MAX     = 4096;

    typedef logic [PIX_W-1:0] t_pix_list[$];

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value so the block never sees an X from the bench.
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_beat              in_beat   = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_beat             out_beat;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    glyph_match_scorer_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_out_ready (out_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard state and run statistics.
    // ------------------------------------------------------------------------
    t_out_beat   pending_results[$];
    int unsigned errors         = 0;
    int unsigned cycles         = 0;
    int unsigned beats_sent     = 0;
    int unsigned live_beats     = 0;
    int unsigned results_seen   = 0;
    int unsigned patches_closed = 0;
    int unsigned settings_used  = 0;
    int unsigned ready_wait     = 0;
    bit          idle_on        = 1'b1;
    t_pix_list   cur_patch;

    // ------------------------------------------------------------------------
    // Behavioral copy of the scorer. The patch memory is only ever read below
    // the current patch length, so entries never written are never looked at.
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0]   ref_bytes [PATCH_LEN_MAX];
    logic [9:0]         ref_len       = '0;
    logic [12:0]        ref_pop       = '0;
    logic               ref_closed    = 1'b0;
    logic [9:0]         glyph_pos     = '0;
    logic [12:0]        glyph_ovl     = '0;
    logic [12:0]        glyph_pop     = '0;
    logic [CODE_W-1:0]  top_code      = '0;
    logic [SCORE_W-1:0] top_score     = '0;
    logic               search_halted = 1'b0;
    logic [NOISE_W-1:0] noise_cfg     = '0;
    logic [SCORE_W-1:0] accept_cfg    = FULL_SCORE;

    // Overlap over union plus the square of the extraneous pixels, in Q1.16.
    // An empty glyph is perfect when the patch is within the noise limit.
    function automatic logic [SCORE_W-1:0] similarity();
        longint unsigned o, g, r, extra, denom, q;
        o = glyph_ovl;
        g = glyph_pop;
        r = ref_pop;
        if (g == 0 && r <= noise_cfg) begin
            return FULL_SCORE;
        end
        extra = g - o;
        denom = r + g - o + extra * extra;
        if (denom == 0) begin
            return '0;
        end
        q = (o << 16) / denom;
        if (q > FULL_SCORE) begin
            q = FULL_SCORE;
        end
        return q[SCORE_W-1:0];
    endfunction

    // Advances the copy by one accepted beat and queues the result it causes.
    // Returns 0 for a glyph beat that the stopped search throws away.
    function automatic bit score_beat(input t_in_beat b);
        logic [PIX_W-1:0]   stored;
        logic [SCORE_W-1:0] s;
        t_out_beat          res;
        if (b.kind == KIND_REF) begin
            // A reference byte after a closed patch opens a new one and
            // forgets the whole search.
            if (ref_closed) begin
                ref_len       = '0;
                ref_pop       = '0;
                ref_closed    = 1'b0;
                glyph_pos     = '0;
                glyph_ovl     = '0;
                glyph_pop     = '0;
                top_code      = '0;
                top_score     = '0;
                search_halted = 1'b0;
            end
            if (ref_len < PATCH_LEN_MAX) begin
                ref_bytes[ref_len] = b.pix_bits;
                ref_len = ref_len + 1'b1;
                ref_pop = ref_pop + 13'($countones(b.pix_bits));
            end
            if (b.last_byte) begin
                ref_closed = 1'b1;
                patches_closed++;
            end
            return 1'b1;
        end
        if (search_halted) begin
            return 1'b0;
        end
        // Positions past the patch compare against zero; positions past the
        // memory are not counted at all.
        if (glyph_pos < PATCH_LEN_MAX) begin
            stored    = (glyph_pos < ref_len) ? ref_bytes[glyph_pos] : '0;
            glyph_ovl = glyph_ovl + 13'($countones(stored & b.pix_bits));
            glyph_pop = glyph_pop + 13'($countones(b.pix_bits));
            glyph_pos = glyph_pos + 1'b1;
        end
        if (!b.last_byte) begin
            return 1'b1;
        end
        s = similarity();
        // Ties go to the later glyph.
        if (s >= top_score) begin
            top_score = s;
            top_code  = b.glyph_code;
            if (s >= accept_cfg) begin
                search_halted = 1'b1;
            end
        end
        glyph_pos = '0;
        glyph_ovl = '0;
        glyph_pop = '0;
        res.glyph_score = s;
        res.best_code   = top_code;
        res.best_score  = top_score;
        res.search_done = search_halted;
        pending_results.push_back(res);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: checks each beat against the oldest prediction and, while
    // idle_on is set, draws a fresh random stall after every beat it takes.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        errors++;
        $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, glyph_score", 0, out_beat.glyph_score);
            end else begin
                want = pending_results.pop_front();
                if (out_beat.glyph_score !== want.glyph_score) begin
                    report_mismatch("glyph_score", want.glyph_score, out_beat.glyph_score);
                end
                if (out_beat.best_code !== want.best_code) begin
                    report_mismatch("best_code", want.best_code, out_beat.best_code);
                end
                if (out_beat.best_score !== want.best_score) begin
                    report_mismatch("best_score", want.best_score, out_beat.best_score);
                end
                if (out_beat.search_done !== want.search_done) begin
                    report_mismatch("search_done", want.search_done, out_beat.search_done);
                end
            end
            ready_wait = idle_on ? $urandom_range(0, 3) : 0;
            out_ready <= (ready_wait == 0);
        end else if (ready_wait != 0) begin
            ready_wait--;
            if (ready_wait == 0) begin
                out_ready <= 1'b1;
            end
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Hard stop in case the block hangs or a prediction is never met.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, pending_results.size());
            $display("FAIL glyph_match_scorer_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Valid stays high between back-to-back beats; it only drops
    // when the random gap before the next beat is not zero.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_in_beat b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        if (score_beat(b)) begin
            live_beats++;
        end
    endtask

    // Sends a whole bitmap. Only the last byte of a glyph carries its real code
    // point; the others carry noise, since the block must take the last one.
    task automatic send_bitmap(input logic kind, input t_pix_list pix,
                               input logic [CODE_W-1:0] code);
        t_in_beat b;
        foreach (pix[i]) begin
            b.kind       = kind;
            b.pix_bits   = pix[i];
            b.last_byte  = (i == pix.size() - 1);
            b.glyph_code = (b.last_byte && kind == KIND_GLYPH) ?
                           code : CODE_W'($urandom_range(0, CODE_MAX));
            send_item(b);
        end
    endtask

    // Stops sending and waits until every predicted result is out, then lets
    // the job queue and the serial divider run dry.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the noise limit and then the accept threshold; only call when idle.
    task automatic write_config(input int unsigned noise, input int unsigned accept);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOISE_LIMIT;
        cfg_data  <= CFG_DATA_W'(noise);
        @(posedge clk);
        cfg_index <= CFG_ACCEPT;
        cfg_data  <= CFG_DATA_W'(accept);
        @(posedge clk);
        cfg_we <= 1'b0;
        noise_cfg  = NOISE_W'(noise);
        accept_cfg = SCORE_W'(accept);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // With the reset settings and no patch, an empty glyph is perfect and
    // stops the search at once; the glyph after it must give nothing.
    task automatic test_reset_defaults();
        send_bitmap(KIND_GLYPH, '{8'h00}, '0);
        send_bitmap(KIND_GLYPH, '{8'hFF}, CODE_W'(CODE_MAX));
        send_bitmap(KIND_REF, '{8'h00}, '0);
        settle();
    endtask

    // Partial overlap, extraneous pixels past the patch end, an empty glyph
    // over the noise limit, a tie, a perfect match, a glyph after the stop,
    // and a new patch sitting exactly at the noise limit.
    task automatic test_scoring_rules();
        write_config(2, FULL_SCORE);
        send_bitmap(KIND_REF, '{8'hF0, 8'h0F, 8'hFF}, '0);
        send_bitmap(KIND_GLYPH, '{8'hF0, 8'h00}, 21'h41);
        send_bitmap(KIND_GLYPH, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 21'h42);
        send_bitmap(KIND_GLYPH, '{8'h00}, 21'h43);
        send_bitmap(KIND_GLYPH, '{8'hF0, 8'h00}, CODE_W'(CODE_MAX));
        send_bitmap(KIND_GLYPH, '{8'hF0, 8'h0F, 8'hFF}, '0);
        send_bitmap(KIND_GLYPH, '{8'hAA}, 21'h44);
        send_bitmap(KIND_REF, '{8'h81}, '0);
        send_bitmap(KIND_GLYPH, '{8'h00}, 21'h45);
        settle();
    endtask

    // A patch longer than the memory: the extra bytes must not count, so the
    // patch holds the largest possible pixel count. An empty glyph falls one
    // pixel over the noise limit; a full glyph with junk past the memory end
    // must still match perfectly.
    task automatic test_patch_overflow();
        t_pix_list pix;
        write_config(NOISE_MAX - 1, FULL_SCORE);
        repeat (PATCH_LEN_MAX + 8) pix.push_back(8'hFF);
        send_bitmap(KIND_REF, pix, '0);
        send_bitmap(KIND_GLYPH, '{8'h00}, 21'h7F);
        pix = {};
        repeat (PATCH_LEN_MAX) pix.push_back(8'hFF);
        repeat (3) pix.push_back(PIX_W'($urandom));
        send_bitmap(KIND_GLYPH, pix, CODE_W'($urandom_range(0, CODE_MAX)));
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Random streams: mostly a patch followed by a few glyphs derived from it,
    // with a sprinkle of stray beats that break the usual order.
    // ------------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] pattern_byte(input int unsigned density);
        case (density)
            0: return PIX_W'($urandom);
            1: return PIX_W'($urandom | $urandom);
            2: return PIX_W'($urandom & $urandom & $urandom);
            default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic random_glyph();
        t_pix_list         pix;
        int                len;
        int unsigned       pick;
        int unsigned       mode;
        logic [PIX_W-1:0]  base;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            len = cur_patch.size();
        end else if (pick < 8) begin
            len = int'(cur_patch.size()) + $urandom_range(0, 6) - 3;
        end else begin
            len = $urandom_range(1, 20);
        end
        if (len < 1) begin
            len = 1;
        end
        mode = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
            base = (i < cur_patch.size()) ? cur_patch[i] : '0;
            case (mode)
                0, 1, 2: pix.push_back(base);
                3, 4: pix.push_back(($urandom_range(0, 2) == 0) ?
                                    base ^ (8'h01 << $urandom_range(0, 7)) : base);
                5: pix.push_back(base & PIX_W'($urandom));
                6: pix.push_back(base | PIX_W'($urandom & $urandom));
                7: pix.push_back('0);
                default: pix.push_back(PIX_W'($urandom));
            endcase
        end
        pick = $urandom_range(0, 9);
        code = (pick == 0) ? '0 : (pick == 1) ? CODE_W'(CODE_MAX) :
               CODE_W'($urandom_range(0, CODE_MAX));
        send_bitmap(KIND_GLYPH, pix, code);
    endtask

    task automatic random_session();
        t_in_beat    b;
        int unsigned len;
        int unsigned density;
        // Stray beats of any kind, often leaving a bitmap unfinished.
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b.kind       = 1'($urandom_range(0, 1));
                b.pix_bits   = PIX_W'($urandom);
                b.glyph_code = CODE_W'($urandom_range(0, CODE_MAX));
                b.last_byte  = 1'($urandom_range(0, 1));
                send_item(b);
            end
        end
        if (cur_patch.size() == 0 || $urandom_range(0, 4) != 0) begin
            len     = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 16) :
                      $urandom_range(17, 64);
            density = $urandom_range(0, 3);
            cur_patch = {};
            repeat (len) cur_patch.push_back(pattern_byte(density));
            send_bitmap(KIND_REF, cur_patch, '0);
        end
        repeat ($urandom_range(1, 6)) random_glyph();
    endtask

    task automatic test_random_streams();
        int unsigned start;
        int unsigned phase;
        int unsigned noise;
        int unsigned accept;
        start = beats_sent;
        phase = 0;
        while (beats_sent - start < RANDOM_ITEMS) begin
            // New setting at each phase boundary, with the block drained first.
            if (beats_sent - start >= phase * PHASE_ITEMS) begin
                settle();
                case (phase % 6)
                    0: begin
                        noise  = 0;
                        accept = FULL_SCORE;
                    end
                    1: begin
                        noise  = NOISE_MAX;
                        accept = 1;
                    end
                    2: begin
                        noise  = $urandom_range(0, 24);
                        accept = $urandom_range(40000, FULL_SCORE);
                    end
                    3: begin
                        noise  = $urandom_range(0, 8);
                        accept = FULL_SCORE;
                    end
                    4: begin
                        noise  = $urandom_range(0, NOISE_MAX);
                        accept = $urandom_range(1, FULL_SCORE);
                    end
                    default: begin
                        noise  = $urandom_range(0, 8);
                        accept = $urandom_range(1, 30000);
                    end
                endcase
                // One phase runs at full rate on both sides.
                idle_on = (phase % 6 != 3);
                write_config(noise, accept);
                phase++;
            end
            random_session();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_scoring_rules();
        test_patch_overflow();
        test_random_streams();
        settle();
        $display("Sent %0d beats (%0d scored or loaded), checked %0d glyph results.",
                 beats_sent, live_beats, results_seen);
        $display("Covered %0d closed patches under %0d register settings, with stalls.",
                 patches_closed, settings_used);
        if (errors == 0) begin
            $display("PASS glyph_match_scorer_top");
        end else begin
            $display("FAIL glyph_match_scorer_top");
        end
        $finish;
    end

endmodule
